FILE: rtl/rv32e_pkg.sv
// shared types and constants for the rv32i subset execute unit
package rv32e_pkg;

    localparam int unsigned NumRegsDefault = 32;
    localparam int unsigned DigitW = 4;
    localparam int unsigned Digits = 32 / DigitW;

    localparam logic [2:0] KindBranch = 3'd0;
    localparam logic [2:0] KindUpper  = 3'd1;
    localparam logic [2:0] KindRegOp  = 3'd2;
    localparam logic [2:0] KindImmOp  = 3'd3;
    localparam logic [2:0] KindSystem = 3'd4;

    localparam logic [2:0] F3Beq  = 3'b000;
    localparam logic [2:0] F3Bne  = 3'b001;
    localparam logic [2:0] F3Blt  = 3'b100;
    localparam logic [2:0] F3Bge  = 3'b101;
    localparam logic [2:0] F3Bltu = 3'b110;
    localparam logic [2:0] F3Bgeu = 3'b111;
    localparam logic [2:0] F3Add  = 3'b000;

    localparam logic [4:0] RegA7 = 5'd17;
    localparam logic [31:0] ExitCode = 32'd10;

    localparam logic [1:0] StRun  = 2'd0;
    localparam logic [1:0] StHalt = 2'd1;
    localparam logic [1:0] StErr  = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] instr_word;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        taken;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic        dump_valid;
        logic [31:0] dump_value;
        logic        dump_last;
    } t_out_word;

endpackage

FILE: rtl/rv32i_subset_execute.sv
// rv32i subset execute unit: digit-serial alu, register file and pc
// an ordinary word passes through two register-file reads, one load and 8 digit steps
// of 4 bits before its result is registered
// one word at a time: a new word is not accepted until the last result has been taken;
// exit dump gives NUM_REGS results, each waiting until the previous one is taken
// reset: synchronous active low; start_pc and pc clear to zero, run state running,
// registers read as zero through per-entry valid bits
module rv32i_subset_execute
    import rv32e_pkg::*;
#(
    parameter int unsigned NUM_REGS = NumRegsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned IdxW = $clog2(NUM_REGS);
    localparam int unsigned CntW = $clog2(Digits + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RDA   = 8'b00000010,
        S_RDB   = 8'b00000100,
        S_EXEC  = 8'b00001000,
        S_DONE  = 8'b00010000,
        S_OUT   = 8'b00100000,
        S_DRD   = 8'b01000000,
        S_DOUT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    // register file memory, valid bits stand in for the reset clear
    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]         r_rdata;
    logic                r_rvld;
    logic                r_rzero;
    logic [4:0]          w_raddr;
    logic                w_we;

    logic [31:0] r_start_pc;
    logic [31:0] r_pc;
    logic [1:0]  r_run;
    t_in_word    r_in;
    logic [31:0] r_a, r_b;      // operand shift registers, low digit out first
    logic [31:0] r_sum;         // result shift register
    logic [31:0] r_pcs;         // pc + offset shift register
    logic        r_cy, r_pcy;
    logic        r_eq;
    logic        r_ltu;
    logic        r_sdiff;       // operand signs differ
    logic [CntW-1:0] r_cnt;
    logic [IdxW:0]   r_didx;
    t_out_word   r_out;
    logic        r_ovalid;

    logic [4:0]  w_rd, w_rs1, w_rs2;
    logic [2:0]  w_f3;
    logic [6:0]  w_f7;
    logic [31:0] w_off, w_imm, w_opb_full;
    logic        w_sub;
    logic [31:0] w_rval;

    assign w_rd  = r_in.instr_word[11:7];
    assign w_f3  = r_in.instr_word[14:12];
    assign w_rs1 = r_in.instr_word[19:15];
    assign w_rs2 = r_in.instr_word[24:20];
    assign w_f7  = r_in.instr_word[31:25];
    assign w_off = {{19{r_in.instr_word[31]}}, r_in.instr_word[31], r_in.instr_word[7],
                    r_in.instr_word[30:25], r_in.instr_word[11:8], 1'b0};
    assign w_imm = {{20{r_in.instr_word[31]}}, r_in.instr_word[31:20]};
    assign w_sub = (r_in.kind == KindRegOp) && (w_f7 != 7'd0);

    // read data: zero for x0, out-of-range numbers and never-written entries
    assign w_rval = (r_rvld && !r_rzero) ? r_rdata : 32'd0;

    always_comb begin
        w_raddr = w_rs2;
        if (r_state == S_RDA) begin
            w_raddr = w_rs1;
        end else if (r_state == S_IDLE && r_run == StRun) begin
            w_raddr = RegA7;
        end else if (r_state == S_DRD || r_state == S_DOUT) begin
            w_raddr = 5'(r_didx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr[IdxW-1:0]];
        r_rvld  <= r_vld[w_raddr[IdxW-1:0]];
        r_rzero <= (w_raddr == 5'd0) || (32'(w_raddr) >= NUM_REGS);
    end

    // execute decision at the end of the digit loop
    logic        w_cond, w_lt_s;
    logic        w_illegal;
    logic        w_wr_ok;
    logic        w_is_wr;
    logic [31:0] w_val;

    // signs differ: the negative operand is the smaller, the unsigned order flips
    assign w_lt_s = r_sdiff ? !r_ltu : r_ltu;
    always_comb begin
        w_illegal = 1'b0;
        w_cond    = 1'b0;
        unique case (w_f3)
            F3Beq:  w_cond = r_eq;
            F3Bne:  w_cond = !r_eq;
            F3Blt:  w_cond = w_lt_s;
            F3Bge:  w_cond = !w_lt_s;
            F3Bltu: w_cond = r_ltu;
            F3Bgeu: w_cond = !r_ltu;
            default: w_illegal = 1'b1;
        endcase
    end

    always_comb begin
        w_is_wr = 1'b0;
        w_val   = r_sum;
        unique case (r_in.kind)
            KindUpper: begin
                w_is_wr = r_in.instr_word[5];
                w_val   = {r_in.instr_word[31:12], 12'd0};
            end
            KindRegOp, KindImmOp: w_is_wr = (w_f3 == F3Add);
            default: w_is_wr = 1'b0;
        endcase
    end
    assign w_wr_ok = w_is_wr && (w_rd != 5'd0) && (32'(w_rd) < NUM_REGS);
    assign w_we    = (r_state == S_DONE) && (r_run == StRun) && w_wr_ok
                     && !(r_in.kind == KindBranch || r_in.kind == KindSystem);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_rd[IdxW-1:0]] <= w_val;
        end
    end

    // digit-serial add: operand a plus (b or imm, inverted for sub/compare)
    logic [DigitW:0] w_dsum;
    logic [DigitW-1:0] w_bd;
    logic              w_inv;
    assign w_inv = w_sub || (r_in.kind == KindBranch);
    assign w_bd  = w_inv ? ~r_b[DigitW-1:0] : r_b[DigitW-1:0];
    assign w_dsum = {1'b0, r_a[DigitW-1:0]} + {1'b0, w_bd} + {{DigitW{1'b0}}, r_cy};

    // pc adder works on its own serial pair: r_pcs holds pc, r_b-like offset in r_offs
    logic [31:0] r_offs;
    logic [DigitW:0] w_pcd;
    assign w_pcd = {1'b0, r_pcs[DigitW-1:0]} + {1'b0, r_offs[DigitW-1:0]}
                   + {{DigitW{1'b0}}, r_pcy};

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && !o_stall) n_state = (r_run == StRun) ? S_RDA : S_OUT;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_EXEC;
            S_EXEC: if (r_cnt == CntW'(Digits)) n_state = S_DONE;
            S_DONE: n_state = (r_in.kind == KindSystem && !r_in.instr_word[20] && r_a7_ten)
                              ? S_DRD : S_OUT;
            S_OUT:  if (!r_ovalid || !i_stall) n_state = S_IDLE;
            S_DRD:  n_state = S_DOUT;
            S_DOUT: if (!r_ovalid || !i_stall) begin
                n_state = (r_didx == (IdxW+1)'(NUM_REGS - 1)) ? S_IDLE : S_DRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic r_a7_ten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start_pc <= 32'd0;
            r_pc       <= 32'd0;
            r_run      <= StRun;
            r_vld      <= '0;
            r_ovalid   <= 1'b0;
            r_cnt      <= '0;
            r_didx     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_start_pc <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (w_we) r_vld[w_rd[IdxW-1:0]] <= 1'b1;
            unique case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_in <= i_data;
                    r_cnt <= '0;
                    if (r_run != StRun) begin
                        r_out <= '0;
                        r_out.status <= r_run;
                        r_out.next_pc <= r_pc;
                        r_out.dump_last <= 1'b1;
                        r_ovalid <= 1'b1;
                    end
                end
                S_RDA: r_a7_ten <= (w_rval == ExitCode);
                S_RDB: begin
                    r_a <= w_rval;
                end
                S_EXEC: begin
                    if (r_cnt == '0) begin
                        // the load step loads b and the offset, sets the carry-in for sub/compare, clears the pc carry
                        r_b    <= (r_in.kind == KindImmOp) ? w_imm : w_rval;
                        r_offs <= (r_state == S_EXEC) ? w_off : 32'd0;
                        r_pcs  <= r_pc;
                        r_cy   <= w_sub || (r_in.kind == KindBranch);
                        r_pcy  <= 1'b0;
                        r_eq   <= 1'b1;
                        r_ltu  <= 1'b0;
                    end
                    r_cnt <= r_cnt + CntW'(1);
                end
                S_DONE: begin
                    r_out <= '0;
                    r_out.dump_last <= 1'b1;
                    r_ovalid <= 1'b1;
                    if (r_in.kind == KindBranch && w_illegal) begin
                        r_run <= StErr;
                        r_out.status <= StErr;
                        r_out.next_pc <= r_pc;
                    end else if (r_in.kind == KindSystem && !r_in.instr_word[20]) begin
                        r_out.next_pc <= r_pc;
                        if (r_a7_ten) begin
                            r_run    <= StHalt;
                            r_ovalid <= 1'b0;
                            r_didx   <= '0;
                        end else begin
                            r_run <= StErr;
                            r_out.status <= StErr;
                        end
                    end else if (r_in.kind == KindBranch && w_cond) begin
                        r_pc <= r_pcs;
                        r_out.taken <= 1'b1;
                        r_out.next_pc <= r_pcs;
                    end else begin
                        r_pc <= r_pc + 32'd4;
                        r_out.next_pc <= r_pc + 32'd4;
                        if (w_we) begin
                            r_out.reg_written <= 1'b1;
                            r_out.dest_reg <= w_rd;
                            r_out.dest_value <= w_val;
                        end
                    end
                end
                // dump: the addressed register stays read until the output is free
                S_DOUT: if (!r_ovalid || !i_stall) begin
                    r_out <= '0;
                    r_out.status <= StHalt;
                    r_out.next_pc <= r_pc;
                    r_out.dump_valid <= 1'b1;
                    r_out.dump_value <= w_rval;
                    r_out.dump_last <= (r_didx == (IdxW+1)'(NUM_REGS - 1));
                    r_ovalid <= 1'b1;
                    r_didx <= r_didx + (IdxW+1)'(1);
                end
                default: ;
            endcase
            // the serial datapath shifts one digit per exec cycle after the load
            if (r_state == S_EXEC && r_cnt != '0) begin
                if (r_cnt == CntW'(1)) r_sdiff <= r_a[31] ^ r_b[31];
                r_a    <= {{DigitW{1'b0}}, r_a[31:DigitW]};
                r_b    <= {{DigitW{1'b0}}, r_b[31:DigitW]};
                r_sum  <= {w_dsum[DigitW-1:0], r_sum[31:DigitW]};
                r_cy   <= w_dsum[DigitW];
                r_offs <= {{DigitW{1'b0}}, r_offs[31:DigitW]};
                r_pcs  <= {w_pcd[DigitW-1:0], r_pcs[31:DigitW]};
                r_pcy  <= w_pcd[DigitW];
                r_eq   <= r_eq && (r_a[DigitW-1:0] == r_b[DigitW-1:0]);
                r_ltu  <= (r_a[DigitW-1:0] < r_b[DigitW-1:0]) ? 1'b1 :
                          (r_a[DigitW-1:0] > r_b[DigitW-1:0]) ? 1'b0 : r_ltu;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_in.kind == KindBranch && w_illegal) |=> r_run == StErr)
        else $error("illegal branch did not set error");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_out))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.dump_valid && r_ovalid |-> r_run == StHalt)
        else $error("dump outside halt");

endmodule

FILE: dv/rv32i_subset_execute_tb.sv
// testbench for the rv32i subset execute unit: random and directed words, self-checking
`timescale 1ns / 100ps

module rv32i_subset_execute_tb;
    import rv32e_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_word   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_word  o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [31:0] i_cfg_data;

    rv32i_subset_execute DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // words waiting to be offered, and results the block still owes us
    t_in_word  instr_queue[$];
    t_out_word retire_queue[$];

    // shadow architectural state
    logic [31:0] gpr [32];
    logic [31:0] shadow_pc;
    logic [1:0]  shadow_state;

    int   mismatches = 0;
    int   words_in = 0;
    bit   in_taken = 1'b0;
    bit   calm = 1'b0;        // no idling on either side
    int   gap_left = 0;
    int   stall_left = 0;
    bit   long_hold_done = 1'b0;

    function automatic logic [31:0] read_gpr(input logic [4:0] n);
        return (n == 5'd0) ? 32'd0 : gpr[n];
    endfunction

    function automatic bit write_gpr(input logic [4:0] n, input logic [31:0] v);
        if (n == 5'd0) return 1'b0;
        gpr[n] = v;
        return 1'b1;
    endfunction

    // one result word with only status, pc and the run-end marker set
    function automatic t_out_word status_word(input logic [1:0] st);
        t_out_word r;
        r = '0;
        r.status = st;
        r.next_pc = shadow_pc;
        r.dump_last = 1'b1;
        return r;
    endfunction

    // execute one word on the shadow state and queue the results it owes
    function automatic void execute_word(input t_in_word it);
        logic [31:0] w, a, b, val, off, imm;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        taken, wr, cond, known;
        t_out_word   r;
        w = it.instr_word;
        rd = w[11:7];
        f3 = w[14:12];
        f7 = w[31:25];
        a = read_gpr(w[19:15]);
        b = read_gpr(w[24:20]);
        taken = 1'b0;
        wr = 1'b0;
        val = '0;
        cond = 1'b0;
        known = 1'b1;
        // halted or faulted: echo stored status, nothing else moves
        if (shadow_state != StRun) begin
            retire_queue.push_back(status_word(shadow_state));
            return;
        end
        case (it.kind)
            KindBranch: begin
                case (f3)
                    F3Beq:   cond = (a == b);
                    F3Bne:   cond = (a != b);
                    F3Blt:   cond = ($signed(a) < $signed(b));
                    F3Bge:   cond = ($signed(a) >= $signed(b));
                    F3Bltu:  cond = (a < b);
                    F3Bgeu:  cond = (a >= b);
                    default: known = 1'b0;
                endcase
                if (!known) begin
                    shadow_state = StErr;
                    retire_queue.push_back(status_word(StErr));
                    return;
                end
                if (cond) begin
                    off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    shadow_pc = shadow_pc + off;
                    taken = 1'b1;
                end
            end
            KindUpper: begin
                // bit 5 picks lui; auipc does nothing
                if (w[5]) begin
                    val = {w[31:12], 12'h000};
                    wr = write_gpr(rd, val);
                end
            end
            KindRegOp: begin
                if (f3 == F3Add) begin
                    val = (f7 != 7'd0) ? a - b : a + b;
                    wr = write_gpr(rd, val);
                end
            end
            KindImmOp: begin
                if (f3 == F3Add) begin
                    imm = {{20{w[31]}}, w[31:20]};
                    val = a + imm;
                    wr = write_gpr(rd, val);
                end
            end
            KindSystem: begin
                // bit 20 clear is ecall; ebreak falls through as a no-op
                if (!w[20]) begin
                    if (read_gpr(RegA7) == ExitCode) begin
                        shadow_state = StHalt;
                        for (int i = 0; i < 32; i++) begin
                            r = '0;
                            r.status = StHalt;
                            r.next_pc = shadow_pc;
                            r.dump_valid = 1'b1;
                            r.dump_value = read_gpr(i[4:0]);
                            r.dump_last = (i == 31);
                            retire_queue.push_back(r);
                        end
                    end else begin
                        shadow_state = StErr;
                        retire_queue.push_back(status_word(StErr));
                    end
                    return;
                end
            end
            default: ;
        endcase
        if (!taken) shadow_pc = shadow_pc + 32'd4;
        r = '0;
        r.status = StRun;
        r.taken = taken;
        r.next_pc = shadow_pc;
        r.reg_written = wr;
        r.dest_reg = wr ? rd : 5'd0;
        r.dest_value = wr ? val : 32'd0;
        r.dump_last = 1'b1;
        retire_queue.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // monitor: predict on every accepted word, check every accepted result
    always @(posedge i_clk) begin
        t_out_word want;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            execute_word(i_data);
            words_in++;
        end
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (retire_queue.size() == 0) begin
                report_mismatch("unexpected word", o_data.next_pc, 32'd0);
            end else begin
                want = retire_queue.pop_front();
                check_field("status", o_data.status, want.status);
                check_field("taken", o_data.taken, want.taken);
                check_field("next_pc", o_data.next_pc, want.next_pc);
                check_field("reg_written", o_data.reg_written, want.reg_written);
                check_field("dest_reg", o_data.dest_reg, want.dest_reg);
                check_field("dest_value", o_data.dest_value, want.dest_value);
                check_field("dump_valid", o_data.dump_valid, want.dump_valid);
                check_field("dump_value", o_data.dump_value, want.dump_value);
                check_field("dump_last", o_data.dump_last, want.dump_last);
            end
        end
    end

    // driver: offer queued words at the falling edge with random gap bursts
    always @(negedge i_clk) begin
        bit next_valid;
        next_valid = 1'b0;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 7);
            end else if (instr_queue.size() > 0) begin
                i_data <= instr_queue.pop_front();
                next_valid = 1'b1;
            end
            i_valid <= next_valid;
        end
    end

    // receiver: random stall bursts, plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (!long_hold_done && words_in >= 60) begin
            long_hold_done = 1'b1;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [31:0] br_word(input logic [2:0] f3, input logic [4:0] rs1,
                                            input logic [4:0] rs2, input logic [12:0] off);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], 7'h63};
    endfunction

    function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, 7'h33};
    endfunction

    function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd);
        return {imm, rs1, f3, rd, 7'h13};
    endfunction

    task automatic push_word(input logic [2:0] kind, input logic [31:0] w);
        t_in_word it;
        it.kind = kind;
        it.instr_word = w;
        instr_queue.push_back(it);
    endtask

    // random word that keeps the block running: no ecall, no unknown branch
    task automatic push_random_word();
        logic [31:0] w;
        logic [2:0]  f3s [6];
        int          pick;
        f3s = '{F3Beq, F3Bne, F3Blt, F3Bge, F3Bltu, F3Bgeu};
        w = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            w[14:12] = f3s[$urandom_range(0, 5)];
            if ($urandom_range(0, 3) == 0) w[24:20] = w[19:15];
            push_word(KindBranch, w);
        end else if (pick < 40) begin
            push_word(KindUpper, w);
        end else if (pick < 65) begin
            w[14:12] = F3Add;
            if ($urandom_range(0, 1) == 0) w[31:25] = 7'd0;
            push_word(KindRegOp, w);
        end else if (pick < 88) begin
            w[14:12] = F3Add;
            push_word(KindImmOp, w);
        end else if (pick < 92) begin
            w[20] = 1'b1;
            push_word(KindSystem, w);
        end else if (pick < 96) begin
            push_word(3'($urandom_range(5, 7)), w);
        end else begin
            w[14:12] = 3'($urandom_range(1, 7));
            push_word($urandom_range(0, 1) ? KindRegOp : KindImmOp, w);
        end
    endtask

    // config write, only while nothing is in flight
    task automatic write_start_pc(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (instr_queue.size() > 0 || i_valid || retire_queue.size() > 0)
            @(posedge i_clk);
        // then let the block settle so it is fully idle
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        shadow_pc = '0;
        shadow_state = StRun;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pc never loads from start_pc, so config writes must not move pc
        write_start_pc(32'h0000_0000);

        // directed: extremes, every operation, the no-op kinds
        push_word(KindUpper, {20'hFFFFF, 5'd1, 7'h37});              // lui x1
        push_word(KindUpper, {20'hABCDE, 5'd9, 7'h17});              // auipc is a no-op
        push_word(KindImmOp, i_word(12'h800, 5'd0, F3Add, 5'd2));    // addi -2048
        push_word(KindImmOp, i_word(12'h7FF, 5'd0, F3Add, 5'd3));    // addi 2047
        push_word(KindRegOp, r_word(7'd0, 5'd2, 5'd1, F3Add, 5'd4)); // add
        push_word(KindRegOp, r_word(7'h20, 5'd3, 5'd4, F3Add, 5'd5)); // sub
        push_word(KindRegOp, r_word(7'h7F, 5'd5, 5'd0, F3Add, 5'd6)); // odd funct7 is sub
        push_word(KindRegOp, r_word(7'd0, 5'd1, 5'd1, F3Add, 5'd0)); // write to x0 dropped
        push_word(KindImmOp, i_word(12'hFFF, 5'd1, F3Add, 5'd0));
        push_word(KindRegOp, r_word(7'd0, 5'd1, 5'd2, 3'b111, 5'd7)); // other funct3
        push_word(KindImmOp, i_word(12'h123, 5'd1, 3'b010, 5'd7));
        push_word(KindBranch, br_word(F3Beq, 5'd0, 5'd0, 13'h0FFE)); // largest forward
        push_word(KindBranch, br_word(F3Bne, 5'd0, 5'd0, 13'h0010));
        push_word(KindBranch, br_word(F3Blt, 5'd2, 5'd3, 13'h1000)); // largest back
        push_word(KindBranch, br_word(F3Bge, 5'd2, 5'd3, 13'h0020));
        push_word(KindBranch, br_word(F3Bge, 5'd3, 5'd3, 13'h1FFE));
        push_word(KindBranch, br_word(F3Bltu, 5'd3, 5'd2, 13'h0040));
        push_word(KindBranch, br_word(F3Bgeu, 5'd3, 5'd2, 13'h0044));
        push_word(KindSystem, 32'h0010_0073);                        // ebreak
        push_word(3'd5, 32'hFFFF_FFFF);
        push_word(3'd6, 32'h0000_0000);
        push_word(3'd7, 32'h5A5A_A5A5);
        wait_drained();

        // sender waits here until every result has come back
        write_start_pc(32'hFFFF_FFFF);
        for (int n = 0; n < 160; n++) push_random_word();
        wait_drained();

        write_start_pc($urandom);
        for (int n = 0; n < 160; n++) push_random_word();
        wait_drained();

        // last stretch at full rate
        write_start_pc(32'h8000_0000);
        calm = 1'b1;
        for (int n = 0; n < 160; n++) push_random_word();

        // end of program: clean exit, a bad ecall, or an unknown branch
        case ($urandom_range(0, 2))
            0: begin
                push_word(KindImmOp, i_word(12'd10, 5'd0, F3Add, RegA7));
                push_word(KindSystem, 32'h0000_0073);
            end
            1: begin
                push_word(KindImmOp, i_word(12'd11, 5'd0, F3Add, RegA7));
                push_word(KindSystem, 32'h0000_0073);
            end
            default: push_word(KindBranch, br_word(3'($urandom_range(2, 3)), 5'd1, 5'd2,
                                                   13'h0008));
        endcase
        // words after the block has stopped
        for (int n = 0; n < 6; n++) push_random_word();
        push_word(KindSystem, 32'h0000_0073);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (retire_queue.size() != 0)
            report_mismatch("results never arrived", retire_queue.size(), 32'd0);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/rv32e_pkg.sv
rtl/rv32i_subset_execute.sv
dv/rv32i_subset_execute_tb.sv
